/* src/hpe_pkg.sv */
// ---------------------------------------------------------------------------
// hpe_pkg
// Shared types, constants and helpers for the histogram percentile engine.
// ---------------------------------------------------------------------------
package hpe_pkg;

  localparam int INNER_BINS = 1024;
  localparam int NBINS      = INNER_BINS + 2;
  localparam int ADDR_W     = $clog2(NBINS);
  localparam int DIV_CNT_W  = 7;

  localparam logic [62:0] SUM_CAP = 63'h4000_0000_0000_0000;
  localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;

  // item opcodes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH  = 2'd2;

  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic        [30:0] bin_width;
  } hpe_cfg_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR,
    S_ADD_BIN, S_ADD_DIV, S_ADD_RD, S_ADD_WR,
    S_SUM_RD, S_SUM_ACC, S_CHECK,
    S_WALK_RD, S_WALK_CHK, S_WALK_DIV, S_WALK_TEST,
    S_AVG, S_EDGE, S_SPLIT, S_FRAC, S_MUL, S_FIN,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_ACCEPT, CMD_CLR_STEP,
    CMD_ADD_BIN, CMD_ADD_IDX, CMD_ADD_WRITE,
    CMD_SUM_ACC, CMD_WALK_CHK, CMD_WALK_HIT, CMD_WALK_NEXT,
    CMD_AVG_START, CMD_AVG_DONE, CMD_EDGE, CMD_SPLIT,
    CMD_FRAC_DONE, CMD_MUL, CMD_FIN, CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic addr_last;
    logic add_inner;
    logic walk_zero;
    logic walk_full;
    logic walk_hit;
    logic total_zero;
    logic est_final;
    logic out_free;
  } hpe_status_t;

  // clamp a signed 64-bit value into 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* src/hpe_div.sv */
// ---------------------------------------------------------------------------
// hpe_div
// Shared restoring divider, one quotient bit per cycle. The remainder
// starts at r_init and the dividend bits shift in from d_init.
// ---------------------------------------------------------------------------
module hpe_div
  import hpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          r_init,
  input  logic [63:0]          d_init,
  input  logic [63:0]          divisor,
  input  logic [DIV_CNT_W-1:0] steps,
  output logic                 busy,
  output logic [63:0]          quot
);

  logic [63:0]          rem;
  logic [63:0]          dvd;
  logic [63:0]          dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic [63:0]          rem_sh;
  logic                 ge;

  // one shift-compare-subtract step
  assign rem_sh = {rem[62:0], dvd[63]};
  assign ge     = rem_sh >= dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= r_init;
      dvd  <= d_init;
      dsr  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? rem_sh - dsr : rem_sh;
      dvd  <= {dvd[62:0], 1'b0};
      quot <= {quot[62:0], ge};
    end
  end

endmodule

/* src/hpe_datapath.sv */
// ---------------------------------------------------------------------------
// hpe_datapath
// Bin memories, running statistics, query registers, divider, multiplier
// and the result register. Acts on one command per cycle.
// ---------------------------------------------------------------------------
module hpe_datapath
  import hpe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  hpe_cfg_t            cfg,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  sample_value,
  input  logic [15:0]         sample_count,
  input  logic [15:0]         quantile,
  input  logic                out_stall,
  output hpe_status_t         status,
  output logic                out_valid,
  output logic signed [31:0]  estimate,
  output logic [47:0]         total_seen,
  output logic signed [31:0]  lowest_seen,
  output logic signed [31:0]  highest_seen,
  output logic                is_empty
);

  // bin storage
  logic        [47:0] cnt_mem [NBINS];
  logic signed [63:0] sum_mem [NBINS];
  logic        [47:0] rd_cnt;
  logic signed [63:0] rd_sum;
  logic               mem_we;
  logic        [47:0] wr_cnt;
  logic signed [63:0] wr_sum;

  // latched item and running statistics
  logic [1:0]         op_r;
  logic signed [31:0] val_r;
  logic [15:0]        cnt_r;
  logic [15:0]        quant_r;
  logic [ADDR_W-1:0]  addr;
  logic signed [31:0] run_min;
  logic signed [31:0] run_max;
  logic [47:0]        wtotal;
  logic signed [47:0] prod;

  // query registers
  logic [62:0]        total;
  logic [62:0]        cum;
  logic [32:0]        lo_p;
  logic [32:0]        hi_p;
  logic [ADDR_W-1:0]  idx;
  logic signed [63:0] avg;
  logic signed [63:0] lo;
  logic signed [63:0] hi;
  logic signed [63:0] base;
  logic [35:0]        mval;
  logic [31:0]        tfrac;
  logic [63:0]        mlo;
  logic [35:0]        mhi;
  logic signed [31:0] est;

  // divider hookup
  logic                 div_start;
  logic [63:0]          div_r;
  logic [63:0]          div_d;
  logic [63:0]          div_b;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 div_busy;
  logic [63:0]          quot;

  // derived values
  logic [30:0]        w_eff;
  logic signed [63:0] rl;
  logic signed [63:0] rh;
  logic               below;
  logic               above;
  logic signed [32:0] diff;
  logic [31:0]        p;
  logic [63:0]        tot_sum;
  logic [62:0]        tot_next;
  logic [63:0]        cum_sum;
  logic [62:0]        cum_next;
  logic               idx_first;
  logic               idx_last;
  logic [33:0]        mid_sum;
  logic [32:0]        mid;
  logic               lower;
  logic               eq_p;
  logic               fin_under;
  logic               fin_over;
  logic               fin_inner;
  logic [63:0]        abs_sum;
  logic [48:0]        cnt_add;
  logic [48:0]        tot_add;
  logic signed [64:0] sum_add;
  logic [41:0]        edge_prod;
  logic signed [63:0] lo_inner;
  logic signed [63:0] fin_sum;
  logic signed [63:0] half_sum;

  assign w_eff    = (cfg.bin_width == '0) ? 31'd1 : cfg.bin_width;
  assign rl       = 64'(cfg.range_low);
  assign rh       = 64'(cfg.range_high);
  assign below    = val_r < cfg.range_low;
  assign above    = val_r >= cfg.range_high;
  assign diff     = 33'(val_r) - 33'(cfg.range_low);
  assign p        = {quant_r, 16'h0000};

  // saturating running sums of counts
  assign tot_sum  = {1'b0, total} + {16'h0000, rd_cnt};
  assign tot_next = (tot_sum > {1'b0, SUM_CAP}) ? SUM_CAP : tot_sum[62:0];
  assign cum_sum  = {1'b0, cum} + {16'h0000, rd_cnt};
  assign cum_next = (cum_sum > {1'b0, SUM_CAP}) ? SUM_CAP : cum_sum[62:0];

  // interpolation split
  assign idx_first = idx == '0;
  assign idx_last  = idx == ADDR_W'(NBINS - 1);
  assign mid_sum   = {1'b0, lo_p} + {1'b0, hi_p};
  assign mid       = mid_sum[33:1];
  assign lower     = {1'b0, p} < mid;
  assign eq_p      = lo_p == hi_p;
  assign fin_under = idx_first && (avg > rl);
  assign fin_over  = idx_last && (avg < rh);
  assign fin_inner = !idx_first && !idx_last && ((avg < lo) || (avg > hi));
  assign half_sum  = (lo + hi) / 2;
  assign abs_sum   = rd_sum[63] ? 64'(-rd_sum) : 64'(rd_sum);
  assign fin_sum   = base + 64'(mhi) + 64'(mlo[63:32]);

  // inner bin edges
  assign edge_prod = 42'(idx - 1'b1) * 42'(cfg.bin_width);
  assign lo_inner  = rl + 64'(edge_prod);

  // add arithmetic with saturation
  assign cnt_add = {1'b0, rd_cnt} + 49'(cnt_r);
  assign tot_add = {1'b0, wtotal} + 49'(cnt_r);
  assign sum_add = 65'(rd_sum) + 65'(prod);

  always_comb begin
    wr_cnt = cnt_add[48] ? CNT_MAX : cnt_add[47:0];
    if (sum_add[64] != sum_add[63])
      wr_sum = sum_add[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    else
      wr_sum = sum_add[63:0];
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_r     = '0;
    div_d     = '0;
    div_b     = '0;
    div_steps = DIV_CNT_W'(32);
    case (cmd)
      CMD_ADD_BIN: begin
        div_start = !below && !above;
        div_d     = {diff[31:0], 32'h0000_0000};
        div_b     = 64'(w_eff);
      end
      CMD_WALK_CHK: begin
        div_start = (rd_cnt != '0) && (cum_next < total);
        div_r     = 64'(cum_next);
        div_b     = 64'(total);
      end
      CMD_AVG_START: begin
        div_start = 1'b1;
        div_d     = abs_sum;
        div_b     = 64'(rd_cnt);
        div_steps = DIV_CNT_W'(64);
      end
      CMD_SPLIT: begin
        div_start = !status.est_final;
        div_r     = lower ? 64'({1'b0, p} - lo_p) : 64'({1'b0, p} - mid);
        div_b     = lower ? 64'(mid - lo_p) : 64'(hi_p - mid);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  hpe_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .r_init  (div_r),
    .d_init  (div_d),
    .divisor (div_b),
    .steps   (div_steps),
    .busy    (div_busy),
    .quot    (quot)
  );

  // status toward the controller
  always_comb begin
    status.div_busy   = div_busy;
    status.addr_last  = addr == ADDR_W'(NBINS - 1);
    status.add_inner  = !below && !above;
    status.walk_zero  = rd_cnt == '0;
    status.walk_full  = cum_next >= total;
    status.walk_hit   = {1'b0, p} < hi_p;
    status.total_zero = total == '0;
    status.est_final  = eq_p || fin_under || fin_over || fin_inner;
    status.out_free   = !out_valid || !out_stall;
  end

  // bin memories, registered read
  assign mem_we = (cmd == CMD_CLR_STEP) || (cmd == CMD_ADD_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[addr] <= (cmd == CMD_CLR_STEP) ? '0 : wr_cnt;
      sum_mem[addr] <= (cmd == CMD_CLR_STEP) ? '0 : wr_sum;
    end
    rd_cnt <= cnt_mem[addr];
    rd_sum <= sum_mem[addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      out_valid <= 1'b0;
      run_min   <= 32'sh7FFF_FFFF;
      run_max   <= 32'sh8000_0000;
      wtotal    <= '0;
    end else begin
      if (cmd == CMD_OUT_LOAD) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd)
        CMD_ACCEPT: addr <= '0;
        CMD_CLR_STEP: begin
          addr    <= status.addr_last ? '0 : addr + 1'b1;
          run_min <= 32'sh7FFF_FFFF;
          run_max <= 32'sh8000_0000;
          wtotal  <= '0;
        end
        CMD_ADD_BIN: begin
          if (below) addr <= '0;
          else if (above) addr <= ADDR_W'(NBINS - 1);
        end
        CMD_ADD_IDX: begin
          if (quot[31:0] >= 32'(INNER_BINS)) addr <= ADDR_W'(INNER_BINS);
          else addr <= ADDR_W'(quot[31:0] + 32'd1);
        end
        CMD_ADD_WRITE: begin
          if (val_r < run_min) run_min <= val_r;
          if (val_r > run_max) run_max <= val_r;
          wtotal <= tot_add[48] ? CNT_MAX : tot_add[47:0];
        end
        CMD_SUM_ACC: addr <= status.addr_last ? '0 : addr + 1'b1;
        CMD_WALK_CHK: begin
          if (status.walk_zero) addr <= addr + 1'b1;
        end
        CMD_WALK_NEXT: addr <= addr + 1'b1;
        default: begin
          addr <= addr;
        end
      endcase
    end
  end

  // item and query payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_ACCEPT: begin
        op_r    <= opcode;
        val_r   <= sample_value;
        cnt_r   <= sample_count;
        quant_r <= quantile;
        total   <= '0;
        cum     <= '0;
        lo_p    <= '0;
        hi_p    <= '0;
        est     <= '0;
      end
      CMD_ADD_BIN: prod <= 48'(val_r) * 48'(cnt_r);
      CMD_SUM_ACC: total <= tot_next;
      CMD_WALK_CHK: begin
        if (!status.walk_zero) begin
          lo_p <= hi_p;
          cum  <= cum_next;
          idx  <= addr;
          if (status.walk_full) hi_p <= 33'h1_0000_0000;
        end
      end
      CMD_WALK_HIT: hi_p <= quot[32:0];
      CMD_AVG_DONE: avg <= rd_sum[63] ? -$signed(quot) : $signed(quot);
      CMD_EDGE: begin
        if (idx_first) begin
          hi <= rl;
          lo <= (avg <<< 1) - rl;
        end else if (idx_last) begin
          lo <= rh;
          hi <= (avg <<< 1) - rh;
        end else begin
          lo <= lo_inner;
          hi <= lo_inner + 64'(cfg.bin_width);
        end
      end
      CMD_SPLIT: begin
        if (eq_p) est <= sat32(avg);
        else if (fin_under) est <= 32'sh8000_0000;
        else if (fin_over) est <= 32'sh7FFF_FFFF;
        else if (fin_inner) est <= sat32(half_sum);
        base <= lower ? lo : avg;
        mval <= lower ? 36'(avg - lo) : 36'(hi - avg);
      end
      CMD_FRAC_DONE: tfrac <= quot[31:0];
      CMD_MUL: begin
        mlo <= 64'(mval[31:0]) * 64'(tfrac);
        mhi <= 36'(mval[35:32]) * 36'(tfrac);
      end
      CMD_FIN: est <= sat32(fin_sum);
      default: begin
        est <= est;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd == CMD_OUT_LOAD) begin
      estimate     <= (op_r == OP_QUERY) ? est : 32'sd0;
      total_seen   <= wtotal;
      lowest_seen  <= run_min;
      highest_seen <= run_max;
      is_empty     <= wtotal == '0;
    end
  end

endmodule

/* src/hpe_ctrl.sv */
// ---------------------------------------------------------------------------
// hpe_ctrl
// Sequencer: clearing sweep, add read-modify-write, and the query walk.
// ---------------------------------------------------------------------------
module hpe_ctrl
  import hpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [1:0]  opcode,
  input  hpe_status_t status,
  output logic        in_stall,
  output cmd_t        cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: if (status.addr_last) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (op_t'(opcode))
            OP_ADD:   state_next = S_ADD_BIN;
            OP_CLEAR: state_next = S_CLR;
            OP_QUERY: state_next = S_SUM_RD;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_CLR: if (status.addr_last) state_next = S_DONE;
      S_ADD_BIN: state_next = status.add_inner ? S_ADD_DIV : S_ADD_RD;
      S_ADD_DIV: if (!status.div_busy) state_next = S_ADD_RD;
      S_ADD_RD: state_next = S_ADD_WR;
      S_ADD_WR: state_next = S_DONE;
      S_SUM_RD: state_next = S_SUM_ACC;
      S_SUM_ACC: state_next = status.addr_last ? S_CHECK : S_SUM_RD;
      S_CHECK: state_next = status.total_zero ? S_DONE : S_WALK_RD;
      S_WALK_RD: state_next = S_WALK_CHK;
      S_WALK_CHK: begin
        if (status.walk_zero) state_next = S_WALK_RD;
        else if (status.walk_full) state_next = S_WALK_TEST;
        else state_next = S_WALK_DIV;
      end
      S_WALK_DIV: if (!status.div_busy) state_next = S_WALK_TEST;
      S_WALK_TEST: state_next = status.walk_hit ? S_AVG : S_WALK_RD;
      S_AVG: if (!status.div_busy) state_next = S_EDGE;
      S_EDGE: state_next = S_SPLIT;
      S_SPLIT: state_next = status.est_final ? S_DONE : S_FRAC;
      S_FRAC: if (!status.div_busy) state_next = S_MUL;
      S_MUL: state_next = S_FIN;
      S_FIN: state_next = S_DONE;
      S_DONE: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = CMD_NONE;
    in_stall = state != S_IDLE;
    case (state)
      S_INIT, S_CLR: cmd = CMD_CLR_STEP;
      S_IDLE: if (in_valid) cmd = CMD_ACCEPT;
      S_ADD_BIN: cmd = CMD_ADD_BIN;
      S_ADD_DIV: if (!status.div_busy) cmd = CMD_ADD_IDX;
      S_ADD_WR: cmd = CMD_ADD_WRITE;
      S_SUM_ACC: cmd = CMD_SUM_ACC;
      S_WALK_CHK: cmd = CMD_WALK_CHK;
      S_WALK_DIV: if (!status.div_busy) cmd = CMD_WALK_HIT;
      S_WALK_TEST: cmd = status.walk_hit ? CMD_AVG_START : CMD_WALK_NEXT;
      S_AVG: if (!status.div_busy) cmd = CMD_AVG_DONE;
      S_EDGE: cmd = CMD_EDGE;
      S_SPLIT: cmd = CMD_SPLIT;
      S_FRAC: if (!status.div_busy) cmd = CMD_FRAC_DONE;
      S_MUL: cmd = CMD_MUL;
      S_FIN: cmd = CMD_FIN;
      S_DONE: if (status.out_free) cmd = CMD_OUT_LOAD;
      default: cmd = CMD_NONE;
    endcase
  end

endmodule

/* src/histogram_percentile_engine_core.sv */
// Operations: an add finds its bin (using the divider for an inner bin) and
//   updates it; a clear sweeps every bin; opcode 3 only returns the statistics;
//   a query sums all bins, walks them to the hit bin, then interpolates if needed.
// Throughput: one item at a time, each held until its result loads, plus result stalls.
// Reset: synchronous; a sweep over all 1026 bins then zeroes the bin memories with
//   the input stalled (configuration writes are still taken).
// ---------------------------------------------------------------------------
// histogram_percentile_engine_core
// Weighted histogram with quantile estimation; APB config registers.
// ---------------------------------------------------------------------------
module histogram_percentile_engine_core
  import hpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] sample_value,
  input  logic [15:0]        sample_count,
  input  logic [15:0]        quantile,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] estimate,
  output logic [47:0]        total_seen,
  output logic signed [31:0] lowest_seen,
  output logic signed [31:0] highest_seen,
  output logic               is_empty,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  hpe_cfg_t    cfg;
  hpe_status_t status;
  cmd_t        cmd;
  logic        cfg_we;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_low  <= 32'sd0;
      cfg.range_high <= 32'sd1024;
      cfg.bin_width  <= 31'd1;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_RANGE_LOW:  cfg.range_low  <= pwdata;
        REG_RANGE_HIGH: cfg.range_high <= pwdata;
        REG_BIN_WIDTH:  cfg.bin_width  <= pwdata[30:0];
        default:        cfg.bin_width  <= cfg.bin_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RANGE_LOW:  prdata = cfg.range_low;
      REG_RANGE_HIGH: prdata = cfg.range_high;
      REG_BIN_WIDTH:  prdata = {1'b0, cfg.bin_width};
      default:        prdata = '0;
    endcase
  end

  hpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  hpe_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .opcode       (opcode),
    .sample_value (sample_value),
    .sample_count (sample_count),
    .quantile     (quantile),
    .out_stall    (out_stall),
    .status       (status),
    .out_valid    (out_valid),
    .estimate     (estimate),
    .total_seen   (total_seen),
    .lowest_seen  (lowest_seen),
    .highest_seen (highest_seen),
    .is_empty     (is_empty)
  );

endmodule

/* src/hpe_checker.sv */
// ---------------------------------------------------------------------------
// hpe_checker
// Port-level checks on result beats of the histogram percentile engine.
// ---------------------------------------------------------------------------
module hpe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] estimate,
  input logic [47:0]        total_seen,
  input logic signed [31:0] lowest_seen,
  input logic signed [31:0] highest_seen,
  input logic               is_empty
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(estimate))
    else $error("result beat changed while stalled");

  // empty flag agrees with the total
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (total_seen == 48'd0)))
    else $error("is_empty disagrees with total_seen");

  // an empty histogram estimates zero
  a_est0: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> estimate == 32'sd0)
    else $error("nonzero estimate on empty histogram");

  // recorded weight implies a sane min/max pair
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> lowest_seen <= highest_seen)
    else $error("lowest_seen above highest_seen");

endmodule

bind histogram_percentile_engine_core hpe_checker u_hpe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .estimate     (estimate),
  .total_seen   (total_seen),
  .lowest_seen  (lowest_seen),
  .highest_seen (highest_seen),
  .is_empty     (is_empty)
);
